@@ hdl/jcre_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and the magnitude decode for the coefficient run expander.
// No dependencies; every other file in hdl/ imports this package.
package jcre_pkg;

    localparam int BLOCK_COEFS = 64;
    localparam int IDX_W       = $clog2(BLOCK_COEFS);
    localparam int VALUE_W     = 16;
    localparam int BITS_W      = 15;
    localparam int CMD_Q_DEPTH = 4;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(BLOCK_COEFS - 1);
    localparam logic [7:0]       SYM_EOB    = 8'h00;
    localparam logic [7:0]       SYM_ZRL    = 8'hF0;
    localparam logic [3:0]       RUN_ZRL    = 4'hF;
    localparam logic [IDX_W:0]   ZRL_LEN    = (IDX_W + 1)'(16);

    typedef enum logic
    {
        REQ_DC = 1'b0,
        REQ_AC = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed
    {
        logic [IDX_W-1:0]   start_idx;
        logic [IDX_W-1:0]   end_idx;
        logic [VALUE_W-1:0] value;
        logic               has_value;
        status_t            status;
    } cmd_t;

    function automatic logic [VALUE_W-1:0] decode_mag(input logic [3:0] size,
                                                      input logic [BITS_W-1:0] bits);
        logic [BITS_W-1:0] mask;
        logic [BITS_W-1:0] m;
        logic              top;
        mask = ~({BITS_W{1'b1}} << size);
        m    = bits & mask;
        top  = |(m & (mask ^ (mask >> 1)));
        if (top)
        begin
            return {1'b0, m};
        end
        return {1'b0, m} - {1'b0, mask};
    endfunction

endpackage

@@ hdl/jcre_in_if.sv @@
`timescale 1ns / 1ps
// Input channel: one decoded symbol and its raw magnitude bits per beat.
// Depends on jcre_pkg for field widths.
interface jcre_in_if
    import jcre_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [1:0]        component;
    logic [7:0]        symbol;
    logic [BITS_W-1:0] extra_bits;

    modport source (output valid, req_type, component, symbol, extra_bits, input ready);
    modport sink   (input valid, req_type, component, symbol, extra_bits, output ready);
endinterface

@@ hdl/jcre_out_if.sv @@
`timescale 1ns / 1ps
// Output channel: one coefficient per beat.
// Depends on jcre_pkg for field widths.
interface jcre_out_if
    import jcre_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          coef_index;
    logic signed [VALUE_W-1:0] coef_value;
    logic                      last;
    logic [1:0]                status;

    modport source (output valid, coef_index, coef_value, last, status, input ready);
    modport sink   (input valid, coef_index, coef_value, last, status, output ready);
endinterface

@@ hdl/jpeg_coefficient_run_expander_top.sv @@
`timescale 1ns / 1ps
// Top level of the JPEG coefficient run expander.
// Depends on jcre_pkg, jcre_in_if, jcre_out_if, jcre_front, jcre_cmd_queue, jcre_back.
//
// Usage:
//   in_ch takes one Huffman-decoded symbol per beat (DC category or AC run/size
//   with its raw magnitude bits). out_ch gives one coefficient per beat in zigzag
//   order, with last on index 63 and a status code for invalid or overflowing runs.
//   The front end accepts one item per cycle while the command queue (4 entries)
//   has room; an AC item seen while a DC is expected is taken and dropped.
//   The back end emits one coefficient per cycle while the receiver is ready:
//   an AC value item yields run + 1 output beats, a DC 1, a ZRL 16, and an EOB or
//   an error pad up to 63. With an idle queue an input beat passes the queue and
//   the back end's command register before it goes valid. Output beats come from a
//   register; when the receiver stalls, the beat holds, the expansion holds,
//   and input keeps flowing until the queue fills. Reset clears block position,
//   all DC predictors, the queue and the output valid; the block accepts input
//   in the first cycle after reset.
module jpeg_coefficient_run_expander_top
    import jcre_pkg::*;
#(
    parameter int NUM_COMPONENTS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    jcre_in_if.sink     in_ch,
    jcre_out_if.source  out_ch
);

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    jcre_front #(
        .NUM_COMPONENTS (NUM_COMPONENTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    jcre_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    jcre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_ch    (out_ch)
    );

endmodule

@@ hdl/jcre_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts symbols, tracks block position and DC predictors, and turns
// each item into at most one expansion command. Depends on jcre_pkg, jcre_in_if.
module jcre_front
    import jcre_pkg::*;
#(
    parameter int NUM_COMPONENTS = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    jcre_in_if.sink    in_ch,
    output logic       push_valid,
    input  logic       push_ready,
    output cmd_t       push_cmd
);

    localparam int CW = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [VALUE_W-1:0] pred_reg [NUM_COMPONENTS];
    logic [VALUE_W-1:0] pred;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] dc_sum;
    logic [CW-1:0]      comp_idx;
    logic               comp_ok;
    logic [3:0]         run;
    logic [3:0]         size;
    logic [IDX_W:0]     zrl_sum;
    logic [IDX_W:0]     run_sum;
    logic               emits;
    logic               accept;

    assign run      = in_ch.symbol[7:4];
    assign size     = in_ch.symbol[3:0];
    assign comp_ok  = {1'b0, in_ch.component} < 3'(NUM_COMPONENTS);
    assign comp_idx = CW'(in_ch.component);
    assign pred     = comp_ok ? pred_reg[comp_idx] : '0;
    assign mag      = decode_mag(size, in_ch.extra_bits);
    assign dc_sum   = mag + pred;
    assign zrl_sum  = {1'b0, pos_reg} + ZRL_LEN;
    assign run_sum  = {1'b0, pos_reg} + (IDX_W + 1)'(run);

    assign emits      = (in_ch.req_type == REQ_DC) || (pos_reg != '0);
    assign in_ch.ready = push_ready;
    assign push_valid = in_ch.valid && emits;
    assign accept     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        push_cmd.start_idx = pos_reg;
        push_cmd.end_idx   = LAST_INDEX;
        push_cmd.value     = '0;
        push_cmd.has_value = 1'b0;
        push_cmd.status    = ST_OK;
        pos_next           = '0;
        if (in_ch.req_type == REQ_DC)
        begin
            push_cmd.start_idx = '0;
            push_cmd.end_idx   = '0;
            push_cmd.value     = dc_sum;
            push_cmd.has_value = 1'b1;
            pos_next           = IDX_W'(1);
        end
        else if (pos_reg == '0)
        begin
            pos_next = '0;
        end
        else if (in_ch.symbol == SYM_EOB)
        begin
            pos_next = '0;
        end
        else if (size == '0 && run != RUN_ZRL)
        begin
            push_cmd.status = ST_INVALID;
        end
        else if (in_ch.symbol == SYM_ZRL)
        begin
            if (zrl_sum > (IDX_W + 1)'(BLOCK_COEFS))
            begin
                push_cmd.status = ST_OVERFLOW;
            end
            else
            begin
                push_cmd.end_idx = IDX_W'(zrl_sum - 1'b1);
                pos_next         = IDX_W'(zrl_sum);
            end
        end
        else if (run_sum > (IDX_W + 1)'(LAST_INDEX))
        begin
            push_cmd.status = ST_OVERFLOW;
        end
        else
        begin
            push_cmd.end_idx   = IDX_W'(run_sum);
            push_cmd.value     = mag;
            push_cmd.has_value = 1'b1;
            pos_next           = IDX_W'(run_sum + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int c = 0; c < NUM_COMPONENTS; c++)
            begin
                pred_reg[c] <= '0;
            end
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            if (in_ch.req_type == REQ_DC && comp_ok)
            begin
                pred_reg[comp_idx] <= dc_sum;
            end
        end
    end

endmodule

@@ hdl/jcre_cmd_queue.sv @@
`timescale 1ns / 1ps
// Short command queue between front and back ends.
// Depends on jcre_pkg for cmd_t and the depth.
module jcre_cmd_queue
    import jcre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PW = $clog2(CMD_Q_DEPTH);
    localparam int NW = $clog2(CMD_Q_DEPTH + 1);

    cmd_t          mem [CMD_Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = count_reg != NW'(CMD_Q_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/jcre_back.sv @@
`timescale 1ns / 1ps
// Back end: expands one command into zero beats and an optional value beat, one
// coefficient per cycle unless out_ch stalls, into the output register. Depends on jcre_pkg, jcre_out_if.
module jcre_back
    import jcre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  cmd_t        pop_cmd,
    jcre_out_if.source  out_ch
);

    cmd_t                      cur_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      active_reg;
    logic                      out_valid_reg;
    logic [IDX_W-1:0]          out_index_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic [1:0]                out_status_reg;
    logic                      can_load;
    logic                      at_end;
    logic                      pop;

    assign can_load  = !out_valid_reg || out_ch.ready;
    assign at_end    = idx_reg == cur_reg.end_idx;
    assign pop_ready = !active_reg || (can_load && at_end);
    assign pop       = pop_valid && pop_ready;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.coef_index = out_index_reg;
    assign out_ch.coef_value = out_value_reg;
    assign out_ch.last       = out_last_reg;
    assign out_ch.status     = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (can_load)
            begin
                out_valid_reg <= active_reg;
            end
            if (pop)
            begin
                active_reg <= 1'b1;
            end
            else if (active_reg && can_load && at_end)
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && active_reg)
        begin
            out_index_reg  <= idx_reg;
            out_value_reg  <= (cur_reg.has_value && at_end) ? cur_reg.value : '0;
            out_last_reg   <= idx_reg == LAST_INDEX;
            out_status_reg <= cur_reg.status;
        end
        if (pop)
        begin
            cur_reg <= pop_cmd;
            idx_reg <= pop_cmd.start_idx;
        end
        else if (active_reg && can_load && !at_end)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

endmodule
